>>> design/bhsw_pkg.sv
`default_nettype none
package bhsw_pkg;

    localparam int unsigned PrefixLen = 13;
    localparam int unsigned MinLen    = 20;

    localparam logic [7:0] TagFirstLen = 8'h61;
    localparam logic [7:0] TagLastLen  = 8'h64;
    localparam logic [7:0] TagSkipE    = 8'h65;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BAD_SIG = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        PH_PREFIX   = 7'b0000001,
        PH_TAG      = 7'b0000010,
        PH_LEN_HI   = 7'b0000100,
        PH_LEN_LO   = 7'b0001000,
        PH_SKIP_FLD = 7'b0010000,
        PH_SKIP_E   = 7'b0100000,
        PH_PAYLOAD  = 7'b1000000
    } t_phase;

    // One queue entry: the results that one input byte causes.
    typedef struct packed {
        logic        word_vld;
        logic [31:0] word;
        logic        stat_vld;
        t_status     status;
        logic        tail;
    } t_evt;

endpackage
`default_nettype wire

>>> design/bhsw_front.sv
`default_nettype none
module bhsw_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_fin,
    input  wire logic            i_full,
    output logic                 o_ready,
    output logic                 o_push,
    output bhsw_pkg::t_evt       o_evt
);

    bhsw_pkg::t_phase r_phase, n_phase;
    logic [4:0]       r_count, n_count;
    logic             r_sig, n_sig;
    logic [15:0]      r_skip, n_skip;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [23:0]      r_asm, n_asm;
    logic [1:0]       r_lane, n_lane;
    logic             r_any, n_any;
    logic             accept;
    logic [7:0]       sig_byte;
    logic [15:0]      skip_dec;
    bhsw_pkg::t_evt   evt;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        unique case (r_count[1:0])
            2'd0: sig_byte = 8'h00;
            2'd1: sig_byte = 8'h09;
            2'd2: sig_byte = 8'h0F;
            2'd3: sig_byte = 8'hF0;
            default: sig_byte = 8'h00;
        endcase
    end

    assign skip_dec = (r_skip != 16'd0) ? r_skip - 16'd1 : r_skip;

    always_comb begin
        n_phase  = r_phase;
        n_count  = (r_count < 5'(bhsw_pkg::MinLen)) ? r_count + 5'd1 : r_count;
        n_sig    = r_sig;
        n_skip   = r_skip;
        n_len_hi = r_len_hi;
        n_asm    = r_asm;
        n_lane   = r_lane;
        n_any    = r_any;
        evt      = '0;

        unique case (r_phase)
            bhsw_pkg::PH_PREFIX: begin
                if (r_count < 5'd4 && i_byte != sig_byte) begin
                    n_sig = 1'b0;
                end
                if (r_count >= 5'(bhsw_pkg::PrefixLen - 1)) begin
                    n_phase = bhsw_pkg::PH_TAG;
                end
            end
            bhsw_pkg::PH_TAG: begin
                if (i_byte == bhsw_pkg::TagSkipE) begin
                    n_skip  = 16'd4;
                    n_phase = bhsw_pkg::PH_SKIP_E;
                end else if (i_byte >= bhsw_pkg::TagFirstLen &&
                             i_byte <= bhsw_pkg::TagLastLen) begin
                    n_phase = bhsw_pkg::PH_LEN_HI;
                end else begin
                    n_phase = bhsw_pkg::PH_PAYLOAD;
                    n_asm   = {16'd0, i_byte};
                    n_lane  = 2'd1;
                end
            end
            bhsw_pkg::PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = bhsw_pkg::PH_LEN_LO;
            end
            bhsw_pkg::PH_LEN_LO: begin
                n_skip  = {r_len_hi, i_byte};
                n_phase = ({r_len_hi, i_byte} == 16'd0) ? bhsw_pkg::PH_TAG
                                                        : bhsw_pkg::PH_SKIP_FLD;
            end
            bhsw_pkg::PH_SKIP_FLD: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = bhsw_pkg::PH_TAG;
                end
            end
            bhsw_pkg::PH_SKIP_E: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = bhsw_pkg::PH_PAYLOAD;
                end
            end
            bhsw_pkg::PH_PAYLOAD: begin
                if (r_lane == 2'd3) begin
                    evt.word_vld = r_sig;
                    evt.word     = {r_asm, i_byte};
                    n_any        = 1'b1;
                    n_asm        = 24'd0;
                    n_lane       = 2'd0;
                end else begin
                    n_asm  = {r_asm[15:0], i_byte};
                    n_lane = r_lane + 2'd1;
                end
            end
            default: begin
                n_phase = bhsw_pkg::PH_PREFIX;
            end
        endcase

        if (i_fin) begin
            evt.stat_vld = 1'b1;
            if (n_count < 5'(bhsw_pkg::MinLen)) begin
                evt.status = bhsw_pkg::ST_INVALID;
            end else if (!n_sig) begin
                evt.status = bhsw_pkg::ST_BAD_SIG;
            end else if (!n_any) begin
                evt.status = bhsw_pkg::ST_EMPTY;
            end else begin
                evt.status = bhsw_pkg::ST_OK;
                evt.tail   = (n_phase == bhsw_pkg::PH_PAYLOAD) && (n_lane != 2'd0);
            end
            n_phase  = bhsw_pkg::PH_PREFIX;
            n_count  = 5'd0;
            n_sig    = 1'b1;
            n_skip   = 16'd0;
            n_len_hi = 8'd0;
            n_asm    = 24'd0;
            n_lane   = 2'd0;
            n_any    = 1'b0;
        end
    end

    assign o_push = accept && (evt.word_vld || evt.stat_vld);
    assign o_evt  = evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= bhsw_pkg::PH_PREFIX;
            r_count  <= 5'd0;
            r_sig    <= 1'b1;
            r_skip   <= 16'd0;
            r_len_hi <= 8'd0;
            r_asm    <= 24'd0;
            r_lane   <= 2'd0;
            r_any    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_sig    <= n_sig;
            r_skip   <= n_skip;
            r_len_hi <= n_len_hi;
            r_asm    <= n_asm;
            r_lane   <= n_lane;
            r_any    <= n_any;
        end
    end

endmodule
`default_nettype wire

>>> design/bhsw_fifo.sv
`default_nettype none
module bhsw_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bhsw_pkg::t_evt  i_evt,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output bhsw_pkg::t_evt       o_evt
);

    bhsw_pkg::t_evt r_mem [4];
    logic [1:0]     r_wp, n_wp;
    logic [1:0]     r_rp, n_rp;
    logic [2:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_evt   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 2'd1 : r_wp;
        n_rp  = i_pop ? r_rp + 2'd1 : r_rp;
        n_cnt = r_cnt + {2'd0, i_push} - {2'd0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

>>> design/bhsw_back.sv
`default_nettype none
module bhsw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire bhsw_pkg::t_evt  i_evt,
    output logic                 o_pop,
    input  wire logic            i_tready,
    output logic                 o_tvalid,
    output logic                 o_kind,
    output logic [31:0]          o_word,
    output logic [1:0]           o_status,
    output logic                 o_tail,
    output logic                 o_last
);

    logic              r_valid, n_valid;
    logic              r_pend, n_pend;
    bhsw_pkg::t_status r_pend_st, n_pend_st;
    logic              r_pend_tail, n_pend_tail;
    logic              r_kind, n_kind;
    logic [31:0]       r_word, n_word;
    bhsw_pkg::t_status r_status, n_status;
    logic              r_tail, n_tail;
    logic              r_last, n_last;
    logic              free;

    assign free = !r_valid || i_tready;

    always_comb begin
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_pend_st   = r_pend_st;
        n_pend_tail = r_pend_tail;
        n_kind      = r_kind;
        n_word      = r_word;
        n_status    = r_status;
        n_tail      = r_tail;
        n_last      = r_last;
        o_pop       = 1'b0;
        if (free) begin
            if (r_pend) begin
                n_valid  = 1'b1;
                n_kind   = bhsw_pkg::KIND_STATUS;
                n_word   = 32'd0;
                n_status = r_pend_st;
                n_tail   = r_pend_tail;
                n_last   = 1'b1;
                n_pend   = 1'b0;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_evt.word_vld) begin
                    n_kind      = bhsw_pkg::KIND_WORD;
                    n_word      = i_evt.word;
                    n_status    = bhsw_pkg::ST_OK;
                    n_tail      = 1'b0;
                    n_last      = 1'b0;
                    n_pend      = i_evt.stat_vld;
                    n_pend_st   = i_evt.status;
                    n_pend_tail = i_evt.tail;
                end else begin
                    n_kind   = bhsw_pkg::KIND_STATUS;
                    n_word   = 32'd0;
                    n_status = i_evt.status;
                    n_tail   = i_evt.tail;
                    n_last   = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_st   <= n_pend_st;
        r_pend_tail <= n_pend_tail;
        r_kind      <= n_kind;
        r_word      <= n_word;
        r_status    <= n_status;
        r_tail      <= n_tail;
        r_last      <= n_last;
    end

    assign o_tvalid = r_valid;
    assign o_kind   = r_kind;
    assign o_word   = r_word;
    assign o_status = r_status;
    assign o_tail   = r_tail;
    assign o_last   = r_last;

endmodule
`default_nettype wire

>>> design/fpga_bit_header_strip_word_pack.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata: data_byte; tlast: is_final
// m_axis    out        tdata: payload_word, status, tail_dropped; tuser: kind;
//                      tlast: end_of_run
//
// One input item is taken per cycle while the four-entry result queue has room.
// Each output item passes through the output register, so a byte that
// completes a valid word and ends the file gives two output items: the word, then the status.
// Reset is synchronous and active low and returns the parser to the prefix.
// A stalled output fills the queue and then holds s_axis_tready low.
module fpga_bit_header_strip_word_pack (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] payload_word, [33:32] status,
                                            // [34] tail_dropped, [39:35] zero
    output logic             m_axis_tuser,  // [0] kind
    output logic             m_axis_tlast
);

    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    bhsw_pkg::t_evt front_evt;
    bhsw_pkg::t_evt queue_evt;
    logic [31:0]    word;
    logic [1:0]     status;
    logic           tail;

    bhsw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_fin   (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_evt   (front_evt)
    );

    bhsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_evt   (queue_evt)
    );

    bhsw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_evt    (queue_evt),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_kind   (m_axis_tuser),
        .o_word   (word),
        .o_status (status),
        .o_tail   (tail),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, tail, status, word};

endmodule
`default_nettype wire

>>> tb/fpga_bit_header_strip_word_pack_tb.sv
`default_nettype none
module fpga_bit_header_strip_word_pack_tb;

    localparam logic [31:0] SIG_WORD    = 32'h00090FF0;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 20;

    typedef struct packed {
        logic              kind;
        logic [31:0]       word;
        bhsw_pkg::t_status status;
        logic              tail;
        logic              last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    bhsw_pkg::t_phase prs_phase = bhsw_pkg::PH_PREFIX;
    logic [4:0]  prs_count = '0;
    logic        prs_sig_ok = 1'b1;
    logic [16:0] prs_skip = '0;
    logic [7:0]  prs_len_hi = '0;
    logic [23:0] prs_acc = '0;
    logic [1:0]  prs_lane = '0;
    logic        prs_word_seen = 1'b0;

    t_result     packed_results[$];
    t_result     want_item;
    logic [7:0]  file_bytes[$];

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int words_out = 0;
    int status_out = 0;

    fpga_bit_header_strip_word_pack i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic clear_parser();
        prs_phase     = bhsw_pkg::PH_PREFIX;
        prs_count     = '0;
        prs_sig_ok    = 1'b1;
        prs_skip      = '0;
        prs_len_hi    = '0;
        prs_acc       = '0;
        prs_lane      = '0;
        prs_word_seen = 1'b0;
    endtask

    // Parses one file byte and queues the word and status items it causes.
    task automatic model_file_byte(input logic [7:0] b, input logic fin);
        int                idx;
        t_result           r;
        bhsw_pkg::t_status st;
        logic              tail;
        idx = prs_count;
        if (prs_count < bhsw_pkg::MinLen) prs_count = prs_count + 1'b1;
        case (prs_phase)
            bhsw_pkg::PH_PREFIX: begin
                if (idx < 4 && b != SIG_WORD[31 - 8 * idx -: 8]) prs_sig_ok = 1'b0;
                if (idx + 1 >= bhsw_pkg::PrefixLen) prs_phase = bhsw_pkg::PH_TAG;
            end
            bhsw_pkg::PH_TAG: begin
                if (b == bhsw_pkg::TagSkipE) begin
                    prs_skip  = 17'd4;
                    prs_phase = bhsw_pkg::PH_SKIP_E;
                end else if (b >= bhsw_pkg::TagFirstLen && b <= bhsw_pkg::TagLastLen) begin
                    prs_phase = bhsw_pkg::PH_LEN_HI;
                end else begin
                    prs_phase = bhsw_pkg::PH_PAYLOAD;
                    prs_acc   = {16'h0000, b};
                    prs_lane  = 2'd1;
                end
            end
            bhsw_pkg::PH_LEN_HI: begin
                prs_len_hi = b;
                prs_phase  = bhsw_pkg::PH_LEN_LO;
            end
            bhsw_pkg::PH_LEN_LO: begin
                prs_skip  = {1'b0, prs_len_hi, b};
                prs_phase = (prs_skip == 0) ? bhsw_pkg::PH_TAG : bhsw_pkg::PH_SKIP_FLD;
            end
            bhsw_pkg::PH_SKIP_FLD, bhsw_pkg::PH_SKIP_E: begin
                if (prs_skip > 0) prs_skip = prs_skip - 1'b1;
                if (prs_skip == 0)
                    prs_phase = (prs_phase == bhsw_pkg::PH_SKIP_E) ? bhsw_pkg::PH_PAYLOAD
                                                                   : bhsw_pkg::PH_TAG;
            end
            default: begin
                if (prs_lane == 2'd3) begin
                    if (prs_sig_ok) begin
                        r = '{kind: bhsw_pkg::KIND_WORD, word: {prs_acc, b},
                              status: bhsw_pkg::ST_OK, tail: 1'b0, last: 1'b0};
                        packed_results.push_back(r);
                    end
                    prs_word_seen = 1'b1;
                    prs_acc       = '0;
                    prs_lane      = '0;
                end else begin
                    prs_acc  = {prs_acc[15:0], b};
                    prs_lane = prs_lane + 1'b1;
                end
            end
        endcase
        if (fin) begin
            tail = 1'b0;
            if (prs_count < bhsw_pkg::MinLen) st = bhsw_pkg::ST_INVALID;
            else if (!prs_sig_ok) st = bhsw_pkg::ST_BAD_SIG;
            else if (!prs_word_seen) st = bhsw_pkg::ST_EMPTY;
            else begin
                st   = bhsw_pkg::ST_OK;
                tail = (prs_phase == bhsw_pkg::PH_PAYLOAD && prs_lane != 0);
            end
            r = '{kind: bhsw_pkg::KIND_STATUS, word: 32'h0, status: st, tail: tail,
                  last: 1'b1};
            packed_results.push_back(r);
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) model_file_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (m_axis_tuser == bhsw_pkg::KIND_WORD) words_out++;
                else status_out++;
                if (packed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected output item: kind=%0d tdata=%010h last=%0d",
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want_item = packed_results.pop_front();
                    if (m_axis_tuser !== want_item.kind
                            || m_axis_tdata[31:0] !== want_item.word
                            || m_axis_tdata[33:32] !== want_item.status
                            || m_axis_tdata[34] !== want_item.tail
                            || m_axis_tlast !== want_item.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: expected kind=%0d word=%08h status=%0d %s",
                                     want_item.kind, want_item.word, want_item.status,
                                     $sformatf("tail=%0d last=%0d",
                                               want_item.tail, want_item.last));
                            $display("          got      kind=%0d word=%08h status=%0d %s",
                                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[33:32],
                                     $sformatf("tail=%0d last=%0d",
                                               m_axis_tdata[34], m_axis_tlast));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Stalled for %0d cycles with %0d items outstanding.",
                 STALL_LIMIT, packed_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (packed_results.size() != 0) @(posedge i_clk);
    endtask

    // A bad_idx below four corrupts one bit of that signature byte.
    task automatic put_prefix(input int bad_idx);
        logic [7:0] b;
        for (int i = 0; i < bhsw_pkg::PrefixLen; i++) begin
            b = (i < 4) ? SIG_WORD[31 - 8 * i -: 8] : 8'($urandom);
            if (i == bad_idx) b = b ^ 8'(1 << $urandom_range(7));
            file_bytes.push_back(b);
        end
    endtask

    task automatic put_random_bytes(input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
    endtask

    task automatic put_field(input logic [7:0] tag, input logic [15:0] len);
        file_bytes.push_back(tag);
        file_bytes.push_back(len[15:8]);
        file_bytes.push_back(len[7:0]);
        put_random_bytes(len);
    endtask

    task automatic put_word_bytes(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8 * i +: 8]);
    endtask

    task automatic test_short_and_bad_files();
        file_bytes.push_back(8'h00);
        send_file();
        put_prefix(4);
        file_bytes.push_back(8'hFF);
        put_random_bytes(3);
        send_file();
        put_prefix(4);
        file_bytes.push_back(8'h00);
        put_random_bytes(5);
        send_file();
        put_prefix(4);
        file_bytes.push_back(bhsw_pkg::TagFirstLen - 8'd1);
        put_random_bytes(6);
        send_file();
        put_prefix(3);
        file_bytes.push_back(8'h7F);
        put_random_bytes(7);
        send_file();
        put_prefix(0);
        put_random_bytes(8);
        send_file();
    endtask

    task automatic test_header_fields();
        put_prefix(4);
        put_field(bhsw_pkg::TagFirstLen, 16'h0000);
        put_field(bhsw_pkg::TagFirstLen + 8'd1, 16'h0002);
        put_field(bhsw_pkg::TagFirstLen + 8'd2, 16'h0100);
        put_field(bhsw_pkg::TagLastLen, 16'h0001);
        file_bytes.push_back(bhsw_pkg::TagSkipE + 8'd1);
        put_word_bytes(32'hFFFFFF00);
        put_word_bytes(32'h000000FF);
        put_word_bytes(32'hFFFFFF5A);
        send_file();
        put_prefix(4);
        file_bytes.push_back(bhsw_pkg::TagSkipE);
        put_random_bytes(4);
        put_word_bytes(32'hFF00FF00);
        send_file();
        put_prefix(4);
        file_bytes.push_back(bhsw_pkg::TagFirstLen + 8'd2);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h40);
        put_random_bytes(10);
        send_file();
        put_prefix(4);
        put_field(bhsw_pkg::TagFirstLen, 16'h0002);
        file_bytes.push_back(bhsw_pkg::TagSkipE);
        put_random_bytes(3);
        send_file();
        put_prefix(4);
        file_bytes.push_back(bhsw_pkg::TagSkipE);
        put_random_bytes(6);
        send_file();
    endtask

    // Mostly well-formed files with random content; the rest are noise, carry a bad signature or are cut short.
    task automatic build_random_file();
        int         pick;
        int         cut;
        logic [7:0] b;
        logic [15:0] flen;
        pick = $urandom_range(99);
        if (pick < 15) begin
            put_random_bytes($urandom_range(1, 40));
        end else begin
            put_prefix(($urandom_range(9) == 0) ? $urandom_range(3) : 4);
            repeat ($urandom_range(3)) begin
                flen = ($urandom_range(39) == 0) ? 16'($urandom_range(256, 300))
                                                 : 16'($urandom_range(6));
                put_field(bhsw_pkg::TagFirstLen + 8'($urandom_range(3)), flen);
            end
            if ($urandom_range(1) == 1) begin
                file_bytes.push_back(bhsw_pkg::TagSkipE);
                put_random_bytes(4 + $urandom_range(1, 36));
            end else begin
                do b = 8'($urandom);
                while (b >= bhsw_pkg::TagFirstLen && b <= bhsw_pkg::TagSkipE);
                file_bytes.push_back(b);
                put_random_bytes($urandom_range(35));
            end
            if (pick < 25) begin
                cut = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end
    endtask

    task automatic test_random_files(input int budget);
        int target;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            build_random_file();
            send_file();
            if ($urandom_range(9) == 0) wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        src_idle_pct = 28;
        dst_idle_pct = 53;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_and_bad_files();
        test_header_fields();
        test_random_files(250);
        src_idle_pct = 53;
        dst_idle_pct = 28;
        test_random_files(250);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_files(250);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d files in %0d bytes: short, bad-signature and header-overrun cases,",
                 files_sent, bytes_sent);
        $display("then random files under three idle mixes; %0d words and %0d status items seen.",
                 words_out, status_out);
        if (mismatches == 0 && packed_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d items never arrived.", mismatches,
                     packed_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
